>>> design/bbm_pkg.sv
// Shared types for the byte block median design.
// Holds the word formats of both channels and the bank release record.
// Depends on nothing; the top level, front end and select engine refer to it by scoped names.
package bbm_pkg;

  typedef struct packed {
    logic [7:0] sample;
    logic       last_sample;
  } in_t;

  typedef struct packed {
    logic [7:0] median;
    logic [6:0] sample_count;
    logic       overflow;
  } out_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

endpackage

>>> design/byte_block_median.sv
// Top level of the byte block median: front end, job queue, select engine
// and the two-bank sample store. Depends on bbm_pkg and all bbm_ modules.
//
// Samples are taken one word per cycle while the input is not stalled, into one
// of two store banks; the word marked last closes the block and hands it to the
// select engine, and the next block fills the other bank at once. The engine
// makes eight passes over the N kept samples, one store read per cycle. The
// input stalls only when both banks hold blocks still waiting for their result,
// so the sustained block rate is set by the single read port of the store.
module byte_block_median #(
  parameter int MAX_SAMPLES = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  bbm_pkg::in_t  req,
  output logic          req_stall,
  output logic          res_valid,
  output bbm_pkg::out_t res,
  input  logic          res_stall
);

  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

  logic          wr_en;
  logic [AW:0]   waddr;
  logic [7:0]    wdata;
  logic [AW:0]   raddr;
  logic [7:0]    rdata;
  logic          q_push;
  logic [CW+1:0] q_in;
  logic          q_pop;
  logic [CW+1:0] q_out;
  logic          q_full;
  logic          q_empty;
  bbm_pkg::rel_t rel;

  bbm_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req      (req),
    .req_stall(req_stall),
    .wr_en    (wr_en),
    .waddr    (waddr),
    .wdata    (wdata),
    .job_push (q_push),
    .job      (q_in),
    .q_full   (q_full),
    .rel      (rel)
  );

  bbm_queue #(.WIDTH(CW + 2)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_in),
    .pop      (q_pop),
    .pop_data (q_out),
    .full     (q_full),
    .empty    (q_empty)
  );

  bbm_ram #(.WIDTH(8), .DEPTH(2 ** (AW + 1))) u_store (
    .clk  (clk),
    .wr_en(wr_en),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  bbm_back #(.MAX_SAMPLES(MAX_SAMPLES)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (q_out),
    .q_pop    (q_pop),
    .raddr    (raddr),
    .rdata    (rdata),
    .rel      (rel),
    .res_valid(res_valid),
    .res      (res),
    .res_stall(res_stall)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("Job queue pushed while full.");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("Job queue popped while empty.");

  a_overflow_count: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.overflow) |-> (res.sample_count == 7'(MAX_SAMPLES)))
    else $error("Overflowed block does not report a full store.");

endmodule

>>> design/bbm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module bbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/bbm_queue.sv
// Two-entry job queue between the sample front end and the select engine.
// Depends on nothing; the job word is an opaque vector here.
module bbm_queue #(
  parameter int WIDTH = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       level;

  assign full     = (level == 2'd2);
  assign empty    = (level == 2'd0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      level  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        level <= level + 2'd1;
      end else if (pop && !push) begin
        level <= level - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

>>> design/bbm_front.sv
// Sample front end: accepts words, writes them into the current store bank until
// it is full, counts them and queues one job per block. Depends on bbm_pkg.
module bbm_front #(
  parameter int MAX_SAMPLES = 64,
  localparam int CW = $clog2(MAX_SAMPLES + 1),
  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  bbm_pkg::in_t         req,
  output logic                 req_stall,
  output logic                 wr_en,
  output logic [AW:0]          waddr,
  output logic [7:0]           wdata,
  output logic                 job_push,
  output logic [CW+1:0]        job,
  input  logic                 q_full,
  input  bbm_pkg::rel_t        rel
);

  typedef struct packed {
    logic          bank;
    logic [CW-1:0] count;
    logic          overflow;
  } job_t;

  logic [CW-1:0] fill;
  logic          drop;
  logic          bank;
  logic [1:0]    busy;
  logic [1:0]    busy_next;
  logic          store_full;
  logic          accept;
  job_t          job_s;

  always_comb begin
    store_full     = (fill == CW'(MAX_SAMPLES));
    req_stall      = busy[bank] | q_full;
    accept         = req_valid & ~req_stall;
    wr_en          = accept & ~store_full;
    waddr          = {bank, fill[AW-1:0]};
    wdata          = req.sample;
    job_push       = accept & req.last_sample;
    job_s.bank     = bank;
    job_s.count    = store_full ? fill : CW'(fill + 1'b1);
    job_s.overflow = drop | store_full;
    job            = job_s;
  end

  always_comb begin
    busy_next = busy;
    if (rel.valid) begin
      busy_next[rel.bank] = 1'b0;
    end
    if (job_push) begin
      busy_next[bank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      drop <= 1'b0;
      bank <= 1'b0;
      busy <= 2'b00;
    end else begin
      busy <= busy_next;
      if (accept) begin
        if (req.last_sample) begin
          fill <= '0;
          drop <= 1'b0;
          bank <= ~bank;
        end else if (store_full) begin
          drop <= 1'b1;
        end else begin
          fill <= CW'(fill + 1'b1);
        end
      end
    end
  end

endmodule

>>> design/bbm_back.sv
// Select engine: finds the element of rank count/2 in a stored block by
// eight counting passes, one result bit per pass. Depends on bbm_pkg.
module bbm_back #(
  parameter int MAX_SAMPLES = 64,
  localparam int CW = $clog2(MAX_SAMPLES + 1),
  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  logic [CW+1:0] q_data,
  output logic          q_pop,
  output logic [AW:0]   raddr,
  input  logic [7:0]    rdata,
  output bbm_pkg::rel_t rel,
  output logic          res_valid,
  output bbm_pkg::out_t res,
  input  logic          res_stall
);

  typedef struct packed {
    logic          bank;
    logic [CW-1:0] count;
    logic          overflow;
  } job_t;

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    DECIDE,
    FINISH
  } state_t;

  state_t        state;
  job_t          cur;
  job_t          head;
  logic [CW-1:0] rank;
  logic [CW-1:0] below;
  logic [CW-1:0] issue_idx;
  logic [2:0]    bitpos;
  logic [7:0]    prefix;
  logic          rd_vld;
  logic [7:0]    hi_mask;
  logic          hit;
  logic          issuing;
  logic          out_free;

  always_comb begin
    head     = q_data;
    q_pop    = (state == IDLE) && !q_empty;
    issuing  = (state == SCAN) && (issue_idx != cur.count);
    raddr    = {cur.bank, issue_idx[AW-1:0]};
    hi_mask  = ~(8'hFF >> (3'd7 - bitpos));
    hit      = (((rdata ^ prefix) & hi_mask) == 8'h00) && !rdata[bitpos];
    out_free = !res_valid || !res_stall;
    rel.valid = (state == FINISH) && out_free;
    rel.bank  = cur.bank;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      res_valid <= 1'b0;
      rd_vld    <= 1'b0;
    end else begin
      if ((state == FINISH) && out_free) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      rd_vld <= issuing;
      unique case (state)
        IDLE: begin
          if (!q_empty) begin
            cur       <= head;
            rank      <= head.count >> 1;
            below     <= '0;
            issue_idx <= '0;
            bitpos    <= 3'd7;
            prefix    <= 8'h00;
            state     <= SCAN;
          end
        end
        SCAN: begin
          if (issuing) begin
            issue_idx <= CW'(issue_idx + 1'b1);
          end
          if (rd_vld && hit) begin
            below <= CW'(below + 1'b1);
          end
          if (!issuing && !rd_vld) begin
            state <= DECIDE;
          end
        end
        DECIDE: begin
          if (rank >= below) begin
            prefix[bitpos] <= 1'b1;
            rank           <= rank - below;
          end
          below     <= '0;
          issue_idx <= '0;
          if (bitpos == 3'd0) begin
            state <= FINISH;
          end else begin
            bitpos <= bitpos - 3'd1;
            state  <= SCAN;
          end
        end
        FINISH: begin
          if (out_free) begin
            res.median       <= prefix;
            res.sample_count <= 7'(cur.count);
            res.overflow     <= cur.overflow;
            state            <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
